// ===== sv/dcsp_pkg.sv =====
`default_nettype none

package dcsp_pkg;

    localparam int unsigned SYNC_LEN = 8;

    // result kinds
    localparam logic [3:0] KIND_SYNC        = 4'd0;
    localparam logic [3:0] KIND_RESOLUTION  = 4'd1;
    localparam logic [3:0] KIND_FRAME_PIXEL = 4'd2;
    localparam logic [3:0] KIND_PIXEL       = 4'd3;
    localparam logic [3:0] KIND_LINE        = 4'd4;
    localparam logic [3:0] KIND_TRIANGLE    = 4'd5;
    localparam logic [3:0] KIND_RECTANGLE   = 4'd6;
    localparam logic [3:0] KIND_POLY_VERTEX = 4'd7;
    localparam logic [3:0] KIND_POLY_COLOUR = 4'd8;
    localparam logic [3:0] KIND_ELLIPSE     = 4'd9;
    localparam logic [3:0] KIND_BAD_TYPE    = 4'd10;
    localparam logic [3:0] KIND_FEW_VERTS   = 4'd11;

    // packet type bytes
    localparam logic [2:0] PKT_FRAME     = 3'd0;
    localparam logic [2:0] PKT_PIXEL     = 3'd1;
    localparam logic [2:0] PKT_LINE      = 3'd2;
    localparam logic [2:0] PKT_TRIANGLE  = 3'd3;
    localparam logic [2:0] PKT_RECTANGLE = 3'd4;
    localparam logic [2:0] PKT_POLYGON   = 3'd5;
    localparam logic [2:0] PKT_ELLIPSE   = 3'd6;
    localparam logic [7:0] PKT_TYPE_MAX  = 8'd6;

    localparam logic [7:0] POLY_MIN_VERTS = 8'd3;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [3:0]         result_kind;
        logic signed [31:0] coord_a;
        logic signed [31:0] coord_b;
        logic signed [31:0] coord_c;
        logic signed [31:0] coord_d;
        logic signed [31:0] coord_e;
        logic signed [31:0] coord_f;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } t_result;

    // "VS START"
    function automatic t_byte sync_char(input logic [2:0] idx);
        t_byte c;
        unique case (idx)
            3'd0: c = 8'h56;
            3'd1: c = 8'h53;
            3'd2: c = 8'h20;
            3'd3: c = 8'h53;
            3'd4: c = 8'h54;
            3'd5: c = 8'h41;
            3'd6: c = 8'h52;
            default: c = 8'h54;
        endcase
        return c;
    endfunction

    // coordinate words carried by a fixed-size packet
    function automatic logic [2:0] type_words(input logic [2:0] ptype);
        logic [2:0] w;
        unique case (ptype)
            PKT_PIXEL:     w = 3'd2;
            PKT_LINE:      w = 3'd4;
            PKT_TRIANGLE:  w = 3'd6;
            PKT_RECTANGLE: w = 3'd4;
            PKT_ELLIPSE:   w = 3'd4;
            default:       w = 3'd0;
        endcase
        return w;
    endfunction

    function automatic logic [3:0] type_kind(input logic [2:0] ptype);
        logic [3:0] k;
        unique case (ptype)
            PKT_PIXEL:     k = KIND_PIXEL;
            PKT_LINE:      k = KIND_LINE;
            PKT_TRIANGLE:  k = KIND_TRIANGLE;
            PKT_RECTANGLE: k = KIND_RECTANGLE;
            PKT_ELLIPSE:   k = KIND_ELLIPSE;
            default:       k = KIND_SYNC;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== sv/dcsp_stream_if.sv =====
`default_nettype none

interface dcsp_stream_if #(
    parameter type t_data = logic [7:0]
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/draw_command_stream_parser.sv =====
// A result is valid in o_cmd from the cycle after the byte that completes it is accepted.
// Throughput: one byte per cycle; a byte is taken whenever the output register is empty
// or is being drained in the same cycle, so a stalled result stalls the input only then.
// Reset (synchronous, active low): parser hunts for the sync string, counters and
// resolution clear, output register empties. A bad type, or a polygon vertex count below
// 3 or above 127, halts the parser until the next reset.
`default_nettype none

module draw_command_stream_parser (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    dcsp_stream_if.sink         i_rx,
    dcsp_stream_if.source       o_cmd
);
    import dcsp_pkg::*;

    localparam logic [3:0] PH_SYNC        = 4'd0;
    localparam logic [3:0] PH_HEADER      = 4'd1;
    localparam logic [3:0] PH_TYPE        = 4'd2;
    localparam logic [3:0] PH_FIXED       = 4'd3;
    localparam logic [3:0] PH_FRAME       = 4'd4;
    localparam logic [3:0] PH_POLY_COUNT  = 4'd5;
    localparam logic [3:0] PH_POLY_VERTEX = 4'd6;
    localparam logic [3:0] PH_POLY_COLOUR = 4'd7;
    localparam logic [3:0] PH_HALT        = 4'd8;

    localparam logic [4:0] BPOS_MAX = 5'd26;

    logic [3:0]  r_phase, n_phase;
    logic [2:0]  r_sync_idx, n_sync_idx;
    logic [2:0]  r_ptype, n_ptype;
    logic [4:0]  r_bpos, n_bpos;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_xres, n_xres;
    logic [31:0] r_yres, n_yres;
    logic [31:0] r_col, n_col;
    logic [31:0] r_row, n_row;
    logic [6:0]  r_vleft, n_vleft;
    logic [31:0] r_coord [6];
    logic [7:0]  r_colour [2];

    logic        coord_we;
    logic [2:0]  coord_idx;
    logic        colour_we;
    logic        colour_idx;

    logic        r_out_valid;
    t_result     r_out;
    t_result     n_res;
    logic        emit;

    logic        in_ready;
    logic        in_fire;
    t_byte       rx;
    logic [31:0] rx_sext;
    logic [31:0] shifted;
    logic [2:0]  words;
    logic [4:0]  limit;
    logic [4:0]  over;
    logic [31:0] col_inc;
    logic [31:0] row_inc;
    logic [6:0]  vleft_dec;

    assign in_ready    = !r_out_valid || o_cmd.ready;
    assign in_fire     = i_rx.valid && in_ready;
    assign i_rx.ready  = in_ready;
    assign o_cmd.valid = r_out_valid;
    assign o_cmd.data  = r_out;

    assign rx        = i_rx.data;
    assign rx_sext   = {{24{rx[7]}}, rx};
    assign shifted   = {r_shift[23:0], rx};
    assign words     = type_words(r_ptype);
    assign limit     = {words, 2'b00};
    assign over      = r_bpos - limit;
    assign col_inc   = r_col + 32'd1;
    assign row_inc   = r_row + 32'd1;
    assign vleft_dec = (r_vleft != 7'd0) ? r_vleft - 7'd1 : 7'd0;

    always_comb begin
        n_phase    = r_phase;
        n_sync_idx = r_sync_idx;
        n_ptype    = r_ptype;
        n_bpos     = r_bpos;
        n_shift    = r_shift;
        n_xres     = r_xres;
        n_yres     = r_yres;
        n_col      = r_col;
        n_row      = r_row;
        n_vleft    = r_vleft;
        coord_we   = 1'b0;
        coord_idx  = 3'd0;
        colour_we  = 1'b0;
        colour_idx = 1'b0;
        emit       = 1'b0;
        n_res      = '0;

        unique case (r_phase)
            PH_SYNC: begin
                if (rx == sync_char(r_sync_idx)) begin
                    if (r_sync_idx == 3'(SYNC_LEN - 1)) begin
                        n_sync_idx        = 3'd0;
                        n_bpos            = 5'd0;
                        n_phase           = PH_HEADER;
                        emit              = 1'b1;
                        n_res.result_kind = KIND_SYNC;
                    end else begin
                        n_sync_idx = r_sync_idx + 3'd1;
                    end
                end else begin
                    n_sync_idx = 3'd0;
                end
            end
            PH_HEADER: begin
                n_shift = shifted;
                if (r_bpos == 5'd3) begin
                    n_xres = shifted;
                end
                if (r_bpos >= 5'd7) begin
                    n_yres            = shifted;
                    n_bpos            = 5'd0;
                    n_phase           = PH_TYPE;
                    emit              = 1'b1;
                    n_res.result_kind = KIND_RESOLUTION;
                    n_res.coord_a     = r_xres;
                    n_res.coord_b     = shifted;
                end else begin
                    n_bpos = r_bpos + 5'd1;
                end
            end
            PH_TYPE: begin
                n_bpos = 5'd0;
                if (rx > PKT_TYPE_MAX) begin
                    n_phase           = PH_HALT;
                    emit              = 1'b1;
                    n_res.result_kind = KIND_BAD_TYPE;
                    n_res.coord_a     = rx_sext;
                end else begin
                    n_ptype = rx[2:0];
                    if (rx[2:0] == PKT_FRAME) begin
                        n_col = 32'd0;
                        n_row = 32'd0;
                        // an empty or negative-size frame carries no pixel bytes
                        if (r_xres != 32'd0 && !r_xres[31] && r_yres != 32'd0 && !r_yres[31]) begin
                            n_phase = PH_FRAME;
                        end
                    end else if (rx[2:0] == PKT_POLYGON) begin
                        n_phase = PH_POLY_COUNT;
                    end else begin
                        n_phase = PH_FIXED;
                    end
                end
            end
            PH_FIXED: begin
                if (r_bpos < limit) begin
                    n_shift = shifted;
                    if (r_bpos[1:0] == 2'd3) begin
                        coord_we  = 1'b1;
                        coord_idx = r_bpos[4:2];
                    end
                    n_bpos = r_bpos + 5'd1;
                end else if (over < 5'd2) begin
                    colour_we  = 1'b1;
                    colour_idx = over[0];
                    n_bpos     = r_bpos + 5'd1;
                end else begin
                    emit              = 1'b1;
                    n_res.result_kind = type_kind(r_ptype);
                    n_res.coord_a     = (words > 3'd0) ? r_coord[0] : 32'd0;
                    n_res.coord_b     = (words > 3'd1) ? r_coord[1] : 32'd0;
                    n_res.coord_c     = (words > 3'd2) ? r_coord[2] : 32'd0;
                    n_res.coord_d     = (words > 3'd3) ? r_coord[3] : 32'd0;
                    n_res.coord_e     = (words > 3'd4) ? r_coord[4] : 32'd0;
                    n_res.coord_f     = (words > 3'd5) ? r_coord[5] : 32'd0;
                    n_res.red         = r_colour[0];
                    n_res.green       = r_colour[1];
                    n_res.blue        = rx;
                    n_bpos            = 5'd0;
                    n_phase           = PH_TYPE;
                end
            end
            PH_FRAME: begin
                if (r_bpos < 5'd2) begin
                    colour_we  = 1'b1;
                    colour_idx = r_bpos[0];
                    n_bpos     = r_bpos + 5'd1;
                end else begin
                    emit              = 1'b1;
                    n_res.result_kind = KIND_FRAME_PIXEL;
                    n_res.coord_a     = r_col;
                    n_res.coord_b     = r_row;
                    n_res.red         = r_colour[0];
                    n_res.green       = r_colour[1];
                    n_res.blue        = rx;
                    n_bpos            = 5'd0;
                    n_col             = col_inc;
                    // advance to the next row at the end of a line, and back to the packet type after the last row
                    if (col_inc >= r_xres) begin
                        n_col = 32'd0;
                        n_row = row_inc;
                        if (row_inc >= r_yres) begin
                            n_row   = 32'd0;
                            n_phase = PH_TYPE;
                        end
                    end
                end
            end
            PH_POLY_COUNT: begin
                if (rx < POLY_MIN_VERTS || rx[7]) begin
                    n_phase           = PH_HALT;
                    emit              = 1'b1;
                    n_res.result_kind = KIND_FEW_VERTS;
                    n_res.coord_a     = rx_sext;
                end else begin
                    n_vleft = rx[6:0];
                    n_bpos  = 5'd0;
                    n_phase = PH_POLY_VERTEX;
                end
            end
            PH_POLY_VERTEX: begin
                n_shift = shifted;
                if (r_bpos == 5'd3) begin
                    coord_we  = 1'b1;
                    coord_idx = 3'd0;
                end
                if (r_bpos >= 5'd7) begin
                    emit              = 1'b1;
                    n_res.result_kind = KIND_POLY_VERTEX;
                    n_res.coord_a     = r_coord[0];
                    n_res.coord_b     = shifted;
                    n_bpos            = 5'd0;
                    n_vleft           = vleft_dec;
                    if (vleft_dec == 7'd0) begin
                        n_phase = PH_POLY_COLOUR;
                    end
                end else begin
                    n_bpos = r_bpos + 5'd1;
                end
            end
            PH_POLY_COLOUR: begin
                if (r_bpos < 5'd2) begin
                    colour_we  = 1'b1;
                    colour_idx = r_bpos[0];
                    n_bpos     = r_bpos + 5'd1;
                end else begin
                    emit              = 1'b1;
                    n_res.result_kind = KIND_POLY_COLOUR;
                    n_res.red         = r_colour[0];
                    n_res.green       = r_colour[1];
                    n_res.blue        = rx;
                    n_bpos            = 5'd0;
                    n_phase           = PH_TYPE;
                end
            end
            default: begin
                // halted: drop every byte
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SYNC;
            r_sync_idx  <= 3'd0;
            r_ptype     <= 3'd0;
            r_bpos      <= 5'd0;
            r_shift     <= 32'd0;
            r_xres      <= 32'd0;
            r_yres      <= 32'd0;
            r_col       <= 32'd0;
            r_row       <= 32'd0;
            r_vleft     <= 7'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase    <= n_phase;
                r_sync_idx <= n_sync_idx;
                r_ptype    <= n_ptype;
                r_bpos     <= n_bpos;
                r_shift    <= n_shift;
                r_xres     <= n_xres;
                r_yres     <= n_yres;
                r_col      <= n_col;
                r_row      <= n_row;
                r_vleft    <= n_vleft;
            end
            if (in_fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_cmd.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && emit) begin
            r_out <= n_res;
        end
        if (in_fire && coord_we) begin
            r_coord[coord_idx] <= shifted;
        end
        if (in_fire && colour_we) begin
            r_colour[colour_idx] <= rx;
        end
    end

    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HALT |=> r_phase == PH_HALT)
        else $error("parser left the halted state without reset");

    a_bpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bpos <= BPOS_MAX)
        else $error("byte position beyond the longest packet");

    a_frame_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_FRAME |-> (r_xres != 32'd0 && !r_xres[31] &&
                                 r_yres != 32'd0 && !r_yres[31]))
        else $error("frame pixels decoded with an empty resolution");

    a_sync_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && r_phase == PH_SYNC && r_sync_idx == 3'(SYNC_LEN - 1) &&
        rx == sync_char(r_sync_idx)
        |=> r_out_valid && r_out.result_kind == KIND_SYNC && r_phase == PH_HEADER)
        else $error("completed sync string gave no sync result");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && r_phase == PH_HALT && !r_out_valid |=> !r_out_valid)
        else $error("halted parser issued a result");

endmodule

`default_nettype wire
